// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tem_pkg.sv -----
// ---------------------------------------------------------------------------
// Text extent measure package
// Shared types and constants for the text extent measure block.
// ---------------------------------------------------------------------------
package tem_pkg;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int SUM_W = 20;
	localparam int LH_W = 12;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] CARET_BYTE = 8'h5E;
	localparam int ESC_LEN = 3;

	typedef logic [1:0] esc_cnt_t;
	localparam esc_cnt_t ESC_LAST = esc_cnt_t'(ESC_LEN - 1);

	// Input beat kinds carried on tuser.
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TEXT = 2'd1,
		OP_END  = 2'd2
	} op_t;

	// Work handed from the front end to the measuring stage.
	typedef enum logic [1:0] {
		UOP_NONE,
		UOP_PLAIN,
		UOP_CARET,
		UOP_END
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t kind;
		logic [7:0] code;
	} uop_t;

	typedef enum logic {
		FE_STREAM,
		FE_REPLAY
	} fe_state_t;

	typedef struct packed {
		logic signed [7:0] xoffset;
		logic [7:0] width;
		logic [7:0] advance;
	} glyph_data_t;

	typedef struct packed {
		logic en;
		logic [7:0] code;
		logic present;
		glyph_data_t data;
	} gwr_t;

endpackage

// ----- sv/tem_glyph_table.sv -----
// ---------------------------------------------------------------------------
// Glyph table
// Synchronous glyph memory with per-code presence flags cleared by reset.
// ---------------------------------------------------------------------------
module tem_glyph_table import tem_pkg::*; #(
	parameter int CODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gwr_t        wr,
	input  logic [7:0]  rd_code,
	output logic        rd_present,
	output glyph_data_t rd_data
);

	localparam int AW = $clog2(CODE_COUNT);

	glyph_data_t mem [CODE_COUNT];
	logic [CODE_COUNT-1:0] present_q;
	logic rd_present_q;
	glyph_data_t rd_data_q;
	logic wr_hit;
	logic rd_hit;

	assign wr_hit = wr.en && ({1'b0, wr.code} < 9'(CODE_COUNT));
	assign rd_hit = {1'b0, rd_code} < 9'(CODE_COUNT);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr.code[AW-1:0]] <= wr.data;
		end
		rd_data_q <= mem[rd_code[AW-1:0]];
	end

	// A code never loaded reads as absent, so no clearing pass is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			rd_present_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				present_q[wr.code[AW-1:0]] <= wr.present;
			end
			rd_present_q <= rd_hit && present_q[rd_code[AW-1:0]];
		end
	end

	assign rd_present = rd_present_q;
	assign rd_data = rd_data_q;

endmodule

// ----- sv/tem_front.sv -----
// ---------------------------------------------------------------------------
// Front end
// Decodes input beats, tracks colour escapes and replays cut-off escapes.
// ---------------------------------------------------------------------------
module tem_front import tem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 end_busy,
	output uop_t                 uop,
	output gwr_t                 gwr
);

	fe_state_t state_q, state_d;
	logic esc_pending_q;
	esc_cnt_t esc_cnt_q;
	esc_cnt_t rp_idx_q;
	logic [7:0] esc_buf_q [2];
	logic [7:0] code;
	logic accept;

	assign code = s_tdata[7:0];
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FE_STREAM: begin
				if (accept && s_tuser == OP_END && esc_pending_q) begin
					state_d = FE_REPLAY;
				end
			end
			FE_REPLAY: begin
				if (rp_idx_q == esc_cnt_q) begin
					state_d = FE_STREAM;
				end
			end
			default: state_d = FE_STREAM;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		uop.kind = UOP_NONE;
		uop.code = code;
		gwr.en = 1'b0;
		gwr.code = code;
		gwr.present = s_tdata[8];
		gwr.data.xoffset = s_tdata[16:9];
		gwr.data.width = s_tdata[24:17];
		gwr.data.advance = s_tdata[32:25];
		case (state_q)
			FE_STREAM: begin
				s_tready = (s_tuser != OP_END) || !end_busy;
				if (s_tvalid && s_tready) begin
					case (s_tuser)
						OP_LOAD: gwr.en = 1'b1;
						OP_TEXT: begin
							if (!esc_pending_q) begin
								uop.kind = (code == CARET_BYTE) ? UOP_CARET : UOP_PLAIN;
							end
						end
						OP_END: begin
							if (esc_pending_q) begin
								uop.kind = UOP_PLAIN;
								uop.code = CARET_BYTE;
							end else begin
								uop.kind = UOP_END;
							end
						end
						default: ;
					endcase
				end
			end
			FE_REPLAY: begin
				if (rp_idx_q < esc_cnt_q) begin
					uop.kind = UOP_PLAIN;
					uop.code = esc_buf_q[rp_idx_q[0]];
				end else begin
					uop.kind = UOP_END;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_STREAM;
			esc_pending_q <= 1'b0;
			esc_cnt_q <= '0;
			rp_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (s_tuser)
					OP_TEXT: begin
						if (esc_pending_q) begin
							if (esc_cnt_q == ESC_LAST) begin
								esc_pending_q <= 1'b0;
								esc_cnt_q <= '0;
							end else begin
								esc_cnt_q <= esc_cnt_q + esc_cnt_t'(1);
							end
						end else if (code == CARET_BYTE) begin
							esc_pending_q <= 1'b1;
							esc_cnt_q <= '0;
						end
					end
					OP_END: begin
						esc_pending_q <= 1'b0;
						rp_idx_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == FE_REPLAY) begin
				if (rp_idx_q < esc_cnt_q) begin
					rp_idx_q <= rp_idx_q + esc_cnt_t'(1);
				end else begin
					esc_cnt_q <= '0;
				end
			end
		end
	end

	// Only the first two escape bytes can ever be replayed.
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_TEXT && esc_pending_q && esc_cnt_q != ESC_LAST) begin
			esc_buf_q[esc_cnt_q[0]] <= code;
		end
	end

endmodule

// ----- sv/tem_measure.sv -----
// ---------------------------------------------------------------------------
// Measuring stage
// Folds glyph metrics into line width, maximum width and height sums.
// ---------------------------------------------------------------------------
module tem_measure import tem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [LH_W-1:0]      cfg_data,
	input  uop_t                 uop,
	input  logic                 rd_present,
	input  glyph_data_t          rd_data,
	output logic                 end_busy,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	uop_t uop_s1;
	logic [LH_W-1:0] line_height_q;
	logic [SUM_W-1:0] line_width_q;
	logic [SUM_W-1:0] max_width_q;
	logic [SUM_W-1:0] height_q;
	logic held_valid_q;
	glyph_data_t held_q;
	logic out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic is_nl;
	logic line_end;
	logic signed [9:0] d_end;
	logic signed [9:0] d_step;
	logic signed [21:0] lw_sum;
	logic [SUM_W-1:0] lw_fin;
	logic [SUM_W-1:0] max_fin;
	logic [SUM_W:0] h_sum;
	logic [SUM_W-1:0] h_sat;

	assign is_nl = uop_s1.code == NEWLINE_BYTE;
	assign line_end = (uop_s1.kind == UOP_PLAIN && is_nl) || uop_s1.kind == UOP_END;

	// A held glyph adds its drawn extent at a line end and its advance otherwise.
	always_comb begin
		d_end = $signed({{2{held_q.xoffset[7]}}, held_q.xoffset})
			+ $signed({2'b00, held_q.width});
		d_step = line_end ? d_end : $signed({2'b00, held_q.advance});
		lw_sum = $signed({2'b00, line_width_q}) + $signed({{12{d_step[9]}}, d_step});
		if (!held_valid_q) begin
			lw_fin = line_width_q;
		end else if (lw_sum[21]) begin
			lw_fin = '0;
		end else if (lw_sum[20]) begin
			lw_fin = SUM_MAX;
		end else begin
			lw_fin = lw_sum[SUM_W-1:0];
		end
		max_fin = (lw_fin > max_width_q) ? lw_fin : max_width_q;
		h_sum = {1'b0, height_q} + (SUM_W+1)'(line_height_q);
		h_sat = h_sum[SUM_W] ? SUM_MAX : h_sum[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_s1 <= '0;
			line_height_q <= '0;
			line_width_q <= '0;
			max_width_q <= '0;
			height_q <= '0;
			held_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			uop_s1 <= uop;
			if (cfg_valid) begin
				line_height_q <= cfg_data;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (uop_s1.kind)
				UOP_PLAIN: begin
					held_valid_q <= 1'b0;
					if (is_nl) begin
						height_q <= h_sat;
						max_width_q <= max_fin;
						line_width_q <= '0;
					end else begin
						line_width_q <= lw_fin;
						held_valid_q <= rd_present;
					end
				end
				UOP_CARET: begin
					line_width_q <= lw_fin;
					held_valid_q <= 1'b0;
				end
				UOP_END: begin
					out_valid_q <= 1'b1;
					line_width_q <= '0;
					max_width_q <= '0;
					height_q <= '0;
					held_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (uop_s1.kind == UOP_PLAIN && !is_nl && rd_present) begin
			held_q <= rd_data;
		end
		if (uop_s1.kind == UOP_END) begin
			out_data_q <= {h_sat, max_fin};
		end
	end

	assign end_busy = out_valid_q || uop_s1.kind == UOP_END;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

// ----- sv/text_extent_measure_top.sv -----
// ---------------------------------------------------------------------------
// Text extent measure top level
// Load and text beats are taken one per cycle while no cut-off escape is being replayed; an
// end beat's result passes the measuring stage's work register and then its output register,
// and a further end beat waits until that result has left. An end beat that cuts off a colour
// escape with n held bytes holds s_tready low while those bytes and then the end are issued in
// turn, since each needs the single glyph table read port.
// Reset clears all presence flags and sums at once; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_extent_measure_top import tem_pkg::*; #(
	parameter int CODE_COUNT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input beats.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata from bit 0: code[7:0], glyph_present[8], glyph_xoffset[16:9],
	// glyph_width[24:17], glyph_advance[32:25], zero fill[39:33].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: op[1:0] (0 load glyph entry, 1 text byte, 2 end of text).
	input  logic [1:0]           s_tuser,
	// Result beats.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata from bit 0: text_width[19:0], text_height[39:20].
	output logic [M_TDATA_W-1:0] m_tdata,
	// Line height register write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LH_W-1:0]      cfg_data
);

	// The front end turns each beat into at most one piece of work per cycle.
	// Load beats write the glyph table directly. Text bytes inside a colour
	// escape are absorbed there. An end beat that arrives with an escape still
	// open is expanded into the caret and the held bytes, each read from the
	// glyph table in turn, followed by the end itself.
	uop_t uop;
	gwr_t gwr;
	logic end_busy;
	logic rd_present;
	glyph_data_t rd_data;

	// The line height register is always writable.
	assign cfg_ready = 1'b1;

	tem_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.end_busy (end_busy),
		.uop      (uop),
		.gwr      (gwr)
	);

	// The glyph table is read at the code of every issued piece of work; the
	// data is registered and arrives in the cycle after, lined up with that work
	// in the measuring stage. Writes and reads never share a cycle, so no forwarding is needed.
	tem_glyph_table #(
		.CODE_COUNT (CODE_COUNT)
	) u_glyph_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (gwr),
		.rd_code    (uop.code),
		.rd_present (rd_present),
		.rd_data    (rd_data)
	);

	// The measuring stage keeps the held glyph and the running sums. Its
	// output register lets text beats keep flowing while a result waits;
	// only an end beat waits for that register to drain.
	tem_measure u_measure (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.uop        (uop),
		.rd_present (rd_present),
		.rd_data    (rd_data),
		.end_busy   (end_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// An end is never issued while an earlier result still occupies the output path.
	`TEM_ASSERT_IMP(a_end_no_overrun, clk, arst_n, uop.kind == UOP_END, !end_busy, "end overrun")

	// A glyph write never shares a cycle with work that reads the table.
	`TEM_ASSERT_IMP(a_wr_excl, clk, arst_n, gwr.en, uop.kind == UOP_NONE, "write collides with read")

	// An issued end shows its result after the measuring stage's work register and output register.
	`TEM_ASSERT_NEXT(a_end_latency, clk, arst_n, $past(uop.kind == UOP_END), m_tvalid, "no result")

endmodule
